>>> hdl/kts_pkg.sv
// Shared constants and types for the keyframe translation sampler.
`timescale 1ns / 1ps
`default_nettype none

package kts_pkg;

    localparam int MAX_KEYS = 16;
    localparam int KEY_AW   = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int CNT_W    = $clog2(MAX_KEYS + 1);
    localparam int KEY_W    = 128;

    localparam int DIV_W     = 49;
    localparam int DSR_W     = 32;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);

    localparam logic CFG_KEY_COUNT   = 1'b0;
    localparam logic CFG_LOOP_ENABLE = 1'b1;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DSR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

>>> hdl/kts_ram.sv
// Generic single write port, single registered read port RAM.
`timescale 1ns / 1ps
`default_nettype none

module kts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> hdl/kts_div.sv
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module kts_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire kts_pkg::div_req_t req,
    output kts_pkg::div_rsp_t      rsp
);

    import kts_pkg::*;

    logic [DIV_W-1:0]     dvd_reg;
    logic [DSR_W-1:0]     dsr_reg;
    logic [DSR_W-1:0]     rem_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 done_reg;

    logic [DSR_W:0]   rem_sh;
    logic [DSR_W+1:0] trial;
    logic             qbit;
    logic [DSR_W-1:0] rem_next;

    always_comb
    begin
        rem_sh   = {rem_reg, dvd_reg[DIV_W-1]};
        trial    = {1'b0, rem_sh} - {2'b00, dsr_reg};
        qbit     = ~trial[DSR_W+1];
        rem_next = qbit ? trial[DSR_W-1:0] : rem_sh[DSR_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (req.start)
        begin
            cnt_reg  <= DIV_CNT_W'(DIV_W);
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg  <= cnt_reg - 1'b1;
            done_reg <= (cnt_reg == DIV_CNT_W'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= req.dividend;
            dsr_reg <= req.divisor;
            rem_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            dvd_reg <= {dvd_reg[DIV_W-2:0], qbit};
            rem_reg <= rem_next;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = dvd_reg;

endmodule

`default_nettype wire

>>> hdl/keyframe_translation_sampler.sv
// Top level of the keyframe translation sampler: sequencer and lerp datapath.
//
// Command channel: a word is taken when start is high and busy is low.
// mode 0 stores one keyframe (time, x, y, z) in slot key_index; it is written
// at that same edge, busy never rises and no result follows.
// mode 1 is a tick: the channel time moves on by (tick_delta + 50) / 100,
// saturated, the first enclosing keyframe pair is found, t is divided out and
// each axis is lerped with saturation. One result word follows, shown for
// one cycle with done high; the receiver cannot stall it.
// With key_count below two busy stays low and the tick answers in the next cycle with pos_valid low.
// Otherwise busy stays high while the search walks to the upper key of the
// enclosing pair, or to the last key if none encloses; keys 0 and 1 are used.
// done is high in the first idle cycle, when the next word may be taken.
// Busy time is set by one pass through the one-bit-per-cycle divider for t
// (skipped when the pair has equal times), the search reading one keyframe per
// cycle and three passes through the shared multiplier, which also forms the
// increment by reciprocal multiplication.
// Configuration: cfg_we, cfg_index 0 (key_count) or 1 (loop_enable). The user
// must write them only while idle; the block does not enforce it. Reset clears
// channel time and both registers; keyframe slots hold nothing until loaded.
`timescale 1ns / 1ps
`default_nettype none

module keyframe_translation_sampler (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               mode,
    input  wire logic        [3:0]  key_index,
    input  wire logic        [31:0] key_time_in,
    input  wire logic signed [31:0] key_x_in,
    input  wire logic signed [31:0] key_y_in,
    input  wire logic signed [31:0] key_z_in,
    input  wire logic        [23:0] tick_delta,
    output logic                    done,
    output logic signed      [31:0] pos_x,
    output logic signed      [31:0] pos_y,
    output logic signed      [31:0] pos_z,
    output logic                    pos_valid,
    output logic             [31:0] time_now,
    input  wire logic               cfg_we,
    input  wire logic               cfg_index,
    input  wire logic        [4:0]  cfg_data
);

    import kts_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_INC   = 4'd1;
    localparam logic [3:0] ST_SRCH0 = 4'd2;
    localparam logic [3:0] ST_SRCH  = 4'd3;
    localparam logic [3:0] ST_RDS   = 4'd4;
    localparam logic [3:0] ST_RDE   = 4'd5;
    localparam logic [3:0] ST_RDL   = 4'd6;
    localparam logic [3:0] ST_RDW   = 4'd7;
    localparam logic [3:0] ST_TDIV  = 4'd8;
    localparam logic [3:0] ST_MUL   = 4'd9;
    localparam logic [3:0] ST_ADD   = 4'd10;
    localparam logic [3:0] ST_FIN   = 4'd11;

    localparam logic [1:0] AXIS_LAST = 2'd2;

    // ceil(2^32 / 100): exact for dividends below 2^30
    localparam logic [25:0] INC_RECIP = 26'd42949673;

    // control
    logic [3:0]        state_reg, state_next;
    logic              done_reg, done_next;
    logic [4:0]        key_count_reg;
    logic              loop_enable_reg;
    logic [31:0]       channel_time_reg, channel_time_next;
    logic              div_start_reg, div_start_next;

    // payload
    logic [KEY_AW-1:0] last_reg, last_next;
    logic [KEY_AW-1:0] idx_reg, idx_next;
    logic [KEY_AW-1:0] s_reg, s_next;
    logic [31:0]       now_reg, now_next;
    logic [31:0]       prev_reg, prev_next;
    logic [31:0]       ts_reg, ts_next;
    logic [31:0]       te_reg, te_next;
    logic signed [31:0] a_reg [3];
    logic signed [31:0] a_next [3];
    logic signed [31:0] b_reg [3];
    logic signed [31:0] b_next [3];
    logic signed [31:0] res_reg [3];
    logic signed [31:0] res_next [3];
    logic              loop_hit_reg, loop_hit_next;
    logic              t_neg_reg, t_neg_next;
    logic signed [31:0] t_reg, t_next;
    logic [1:0]        axis_reg, axis_next;
    logic signed [64:0] prod_reg, prod_next;
    logic [DIV_W-1:0]  div_dvd_reg, div_dvd_next;
    logic [DSR_W-1:0]  div_dsr_reg, div_dsr_next;
    logic signed [31:0] pos_x_reg, pos_x_next;
    logic signed [31:0] pos_y_reg, pos_y_next;
    logic signed [31:0] pos_z_reg, pos_z_next;
    logic              pos_valid_reg, pos_valid_next;
    logic [31:0]       time_now_reg, time_now_next;

    // RAM
    logic              ram_we;
    logic [KEY_AW-1:0] ram_waddr;
    logic [KEY_W-1:0]  ram_wdata;
    logic [KEY_AW-1:0] ram_raddr;
    logic [KEY_W-1:0]  ram_rdata;
    logic [31:0]       rd_time;

    div_req_t div_req;
    div_rsp_t div_rsp;

    // combinational helpers
    logic              accept;
    logic [CNT_W-1:0]  n_cur;
    logic [32:0]       now_sum;
    logic signed [32:0] num_s, den_s;
    logic [31:0]       num_mag, den_mag;
    logic signed [32:0] ax_diff;
    logic signed [32:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [64:0] mul_p;
    logic signed [65:0] p_round, q_shift, lerp_sum;
    logic signed [31:0] lerp_sat;
    logic [DIV_W-1:0]  q_div;

    assign accept = start && !busy;
    assign busy   = (state_reg != ST_IDLE);
    assign rd_time = ram_rdata[31:0];

    assign ram_we    = accept && (mode == MODE_LOAD) && (32'(key_index) < 32'(MAX_KEYS));
    assign ram_waddr = KEY_AW'(key_index);
    assign ram_wdata = {key_z_in, key_y_in, key_x_in, key_time_in};

    kts_ram #(
        .WIDTH (KEY_W),
        .DEPTH (MAX_KEYS),
        .AW    (KEY_AW)
    ) u_key_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign div_req.start    = div_start_reg;
    assign div_req.dividend = div_dvd_reg;
    assign div_req.divisor  = div_dsr_reg;

    kts_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        n_cur   = (32'(key_count_reg) > 32'(MAX_KEYS)) ? CNT_W'(MAX_KEYS)
                                                       : CNT_W'(key_count_reg);
        q_div   = div_rsp.quotient;
        ax_diff = 33'(b_reg[axis_reg]) - 33'(a_reg[axis_reg]);
        mul_a   = ax_diff;
        mul_b   = t_reg;
        if (state_reg == ST_INC)
        begin
            mul_a = 33'(div_dvd_reg[24:0]);
            mul_b = 32'(INC_RECIP);
        end
        mul_p   = 65'(mul_a) * 65'(mul_b);
        now_sum = {1'b0, channel_time_reg} + 33'(mul_p[50:32]);
        num_s   = $signed({1'b0, now_reg}) - $signed({1'b0, ts_reg});
        den_s   = $signed({1'b0, te_reg}) - $signed({1'b0, ts_reg});
        num_mag = num_s[32] ? 32'(-num_s) : num_s[31:0];
        den_mag = den_s[32] ? 32'(-den_s) : den_s[31:0];
        p_round = 66'(prod_reg) + 66'sd32768;
        q_shift = p_round >>> 16;
        lerp_sum = 66'(a_reg[axis_reg]) + q_shift;
        if (lerp_sum > 66'sd2147483647)
        begin
            lerp_sat = 32'sh7FFFFFFF;
        end
        else if (lerp_sum < -66'sd2147483648)
        begin
            lerp_sat = 32'sh80000000;
        end
        else
        begin
            lerp_sat = lerp_sum[31:0];
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        done_next         = 1'b0;
        channel_time_next = channel_time_reg;
        div_start_next    = 1'b0;
        last_next         = last_reg;
        idx_next          = idx_reg;
        s_next            = s_reg;
        now_next          = now_reg;
        prev_next         = prev_reg;
        ts_next           = ts_reg;
        te_next           = te_reg;
        a_next            = a_reg;
        b_next            = b_reg;
        res_next          = res_reg;
        loop_hit_next     = loop_hit_reg;
        t_neg_next        = t_neg_reg;
        t_next            = t_reg;
        axis_next         = axis_reg;
        prod_next         = prod_reg;
        div_dvd_next      = div_dvd_reg;
        div_dsr_next      = div_dsr_reg;
        pos_x_next        = pos_x_reg;
        pos_y_next        = pos_y_reg;
        pos_z_next        = pos_z_reg;
        pos_valid_next    = pos_valid_reg;
        time_now_next     = time_now_reg;
        ram_raddr         = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (mode == MODE_TICK))
                begin
                    if (n_cur < CNT_W'(2))
                    begin
                        pos_x_next     = '0;
                        pos_y_next     = '0;
                        pos_z_next     = '0;
                        pos_valid_next = 1'b0;
                        time_now_next  = channel_time_reg;
                        done_next      = 1'b1;
                    end
                    else
                    begin
                        last_next    = KEY_AW'(n_cur - CNT_W'(1));
                        div_dvd_next = DIV_W'({1'b0, tick_delta} + 25'd50);
                        state_next   = ST_INC;
                    end
                end
            end
            ST_INC:
            begin
                now_next   = now_sum[32] ? 32'hFFFFFFFF : now_sum[31:0];
                state_next = ST_SRCH0;
            end
            ST_SRCH0:
            begin
                ram_raddr  = '0;
                idx_next   = '0;
                state_next = ST_SRCH;
            end
            ST_SRCH:
            begin
                ram_raddr = idx_reg + 1'b1;
                if (idx_reg == '0)
                begin
                    prev_next = rd_time;
                    idx_next  = idx_reg + 1'b1;
                end
                else if ((now_reg >= prev_reg) && (now_reg <= rd_time))
                begin
                    s_next     = idx_reg - 1'b1;
                    state_next = ST_RDS;
                end
                else if (idx_reg == last_reg)
                begin
                    s_next     = '0;
                    state_next = ST_RDS;
                end
                else
                begin
                    prev_next = rd_time;
                    idx_next  = idx_reg + 1'b1;
                end
            end
            ST_RDS:
            begin
                ram_raddr  = s_reg;
                state_next = ST_RDE;
            end
            ST_RDE:
            begin
                ram_raddr = s_reg + 1'b1;
                ts_next   = rd_time;
                for (int i = 0; i < 3; i++)
                begin
                    a_next[i] = ram_rdata[32*i+32 +: 32];
                end
                state_next = ST_RDL;
            end
            ST_RDL:
            begin
                ram_raddr = last_reg;
                te_next   = rd_time;
                for (int i = 0; i < 3; i++)
                begin
                    b_next[i] = ram_rdata[32*i+32 +: 32];
                end
                state_next = ST_RDW;
            end
            ST_RDW:
            begin
                loop_hit_next = loop_enable_reg && (now_reg > rd_time);
                axis_next     = '0;
                if (den_s == '0)
                begin
                    t_next     = '0;
                    state_next = ST_MUL;
                end
                else
                begin
                    t_neg_next     = num_s[32] ^ den_s[32];
                    div_dvd_next   = DIV_W'({num_mag, 16'h0000}) + DIV_W'(den_mag[31:1]);
                    div_dsr_next   = den_mag;
                    div_start_next = 1'b1;
                    state_next     = ST_TDIV;
                end
            end
            ST_TDIV:
            begin
                if (div_rsp.done)
                begin
                    if (t_neg_reg)
                    begin
                        t_next = (q_div > DIV_W'(32'h80000000)) ? 32'sh80000000
                                                                 : 32'(-q_div[31:0]);
                    end
                    else
                    begin
                        t_next = (q_div > DIV_W'(32'h7FFFFFFF)) ? 32'sh7FFFFFFF
                                                                 : q_div[31:0];
                    end
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                prod_next  = mul_p;
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                res_next[axis_reg] = lerp_sat;
                if (axis_reg == AXIS_LAST)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    axis_next  = axis_reg + 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_FIN:
            begin
                pos_x_next        = res_reg[0];
                pos_y_next        = res_reg[1];
                pos_z_next        = res_reg[2];
                pos_valid_next    = 1'b1;
                time_now_next     = loop_hit_reg ? 32'h0 : now_reg;
                channel_time_next = loop_hit_reg ? 32'h0 : now_reg;
                done_next         = 1'b1;
                state_next        = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            done_reg         <= 1'b0;
            channel_time_reg <= '0;
            div_start_reg    <= 1'b0;
            key_count_reg    <= '0;
            loop_enable_reg  <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            done_reg         <= done_next;
            channel_time_reg <= channel_time_next;
            div_start_reg    <= div_start_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_KEY_COUNT:   key_count_reg   <= cfg_data;
                    CFG_LOOP_ENABLE: loop_enable_reg <= cfg_data[0];
                    default:         key_count_reg   <= key_count_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg      <= last_next;
        idx_reg       <= idx_next;
        s_reg         <= s_next;
        now_reg       <= now_next;
        prev_reg      <= prev_next;
        ts_reg        <= ts_next;
        te_reg        <= te_next;
        a_reg         <= a_next;
        b_reg         <= b_next;
        res_reg       <= res_next;
        loop_hit_reg  <= loop_hit_next;
        t_neg_reg     <= t_neg_next;
        t_reg         <= t_next;
        axis_reg      <= axis_next;
        prod_reg      <= prod_next;
        div_dvd_reg   <= div_dvd_next;
        div_dsr_reg   <= div_dsr_next;
        pos_x_reg     <= pos_x_next;
        pos_y_reg     <= pos_y_next;
        pos_z_reg     <= pos_z_next;
        pos_valid_reg <= pos_valid_next;
        time_now_reg  <= time_now_next;
    end

    assign done      = done_reg;
    assign pos_x     = pos_x_reg;
    assign pos_y     = pos_y_reg;
    assign pos_z     = pos_z_reg;
    assign pos_valid = pos_valid_reg;
    assign time_now  = time_now_reg;

endmodule

`default_nettype wire
